[src/osp_pkg.sv]
// Package for the offset scaler ping-pong buffer.
// Holds beat payload types, function codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package osp_pkg;

    // Function codes carried in the input beat
    localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZB_RANGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE = 2'd2;

    // Register widths and reset values
    localparam int SCALE_W    = 26;
    localparam int ZB_W       = 16;
    localparam int CFG_DATA_W = SCALE_W;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 26'd35819274; // 546.56 in Q10.16
    localparam logic [ZB_W-1:0]    ZB_RESET    = 16'd10;

    // Saturation limits of the stored word
    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] sample_offset;
        logic [8:0]         read_index;
    } t_in;

    typedef struct packed {
        logic signed [15:0] deviation;
        logic               zero_beat;
        logic               bank_ready;
        logic               ready_bank;
        logic               overrun;
        logic [7:0]         read_data;
        logic               no_pending;
    } t_out;

endpackage

`default_nettype wire

[src/offset_scaler_pingpong_buffer.sv]
// Throughput: one beat per cycle while the output is not stalled; stages are the input
// register, the compute/store stage and the output register.
// The store is one RAM with a registered read port; reads of a bank and writes of
// the filling bank never collide, so the store never inserts a stall.
// Reset (synchronous, active low) clears pipeline valids, bank pointers and pending
// state and loads register defaults; store contents stay undefined, no clearing pass.
`default_nettype none

module offset_scaler_pingpong_buffer #(
    parameter int BANK_BYTES = 512,
    parameter int BANK_COUNT = 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire osp_pkg::t_in                      i_in,
    // output channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output osp_pkg::t_out                          o_out,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [osp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [osp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int BANK_WORDS  = BANK_BYTES / 2;
    localparam int WORD_W      = $clog2(BANK_WORDS);
    localparam int BANK_W      = $clog2(BANK_COUNT);
    localparam int STORE_DEPTH = BANK_WORDS * BANK_COUNT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(BANK_WORDS - 1);
    localparam logic [BANK_W-1:0] LAST_BANK = BANK_W'(BANK_COUNT - 1);

    // Configuration registers
    logic [osp_pkg::SCALE_W-1:0] r_scale;
    logic [osp_pkg::ZB_W-1:0]    r_zb_range;
    logic                        r_raw_mode;

    // Bank bookkeeping
    logic [BANK_W-1:0] r_fill_bank, n_fill_bank;
    logic [WORD_W-1:0] r_fill_word, n_fill_word;
    logic              r_pend_vld,  n_pend_vld;
    logic [BANK_W-1:0] r_pend_bank, n_pend_bank;

    // Pipeline registers
    logic          r_s1_vld;
    osp_pkg::t_in  r_s1;
    logic          r_s2_vld;
    osp_pkg::t_out r_s2;
    logic          r_s2_hit;
    logic          r_s2_hi;
    logic          r_out_vld;
    osp_pkg::t_out r_out;

    // Stage control
    logic w_out_free, w_s2_free, w_adv1;

    // Stage 1 datapath
    logic        w_is_smp, w_is_read, w_is_rel;
    logic [15:0] w_mag;
    logic [41:0] w_prod;
    logic [41:0] w_round;
    logic [25:0] w_r;
    logic [15:0] w_scaled;
    logic [15:0] w_dev;
    logic        w_zb;
    logic        w_bank_ready, w_ovr;
    logic        w_hit;
    osp_pkg::t_out w_s1_res;

    // RAM ports
    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [15:0]       w_rdata;
    logic [7:0]        w_byte;
    osp_pkg::t_out     w_s2_res;

    // Handshake: each stage moves when the one after it is free
    assign w_out_free = !r_out_vld || i_ready;
    assign w_s2_free  = !r_s2_vld || w_out_free;
    assign w_adv1     = r_s1_vld && w_s2_free;
    assign o_ready    = !r_s1_vld || w_s2_free;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= osp_pkg::SCALE_RESET;
            r_zb_range <= osp_pkg::ZB_RESET;
            r_raw_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                osp_pkg::CFG_SCALE:    r_scale    <= i_cfg_wdata;
                osp_pkg::CFG_ZB_RANGE: r_zb_range <= i_cfg_wdata[osp_pkg::ZB_W-1:0];
                osp_pkg::CFG_RAW_MODE: r_raw_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1 <= i_in;
        end
    end

    // Decode function code
    assign w_is_smp  = (r_s1.func == osp_pkg::FUNC_SAMPLE);
    assign w_is_read = (r_s1.func == osp_pkg::FUNC_READ);
    assign w_is_rel  = (r_s1.func == osp_pkg::FUNC_RELEASE);

    // Scale: magnitude times Q10.16 factor, round half away from zero, saturate
    always_comb begin
        w_mag   = r_s1.sample_offset[15] ? 16'(-r_s1.sample_offset) : r_s1.sample_offset;
        w_prod  = 42'(w_mag) * 42'(r_scale);
        w_round = w_prod + 42'h8000;
        w_r     = w_round[41:16];
        if (r_s1.sample_offset[15]) begin
            w_scaled = (w_r >= 26'd32768) ? osp_pkg::SAT_NEG : 16'(16'd0 - w_r[15:0]);
        end else begin
            w_scaled = (w_r > 26'd32767) ? osp_pkg::SAT_POS : w_r[15:0];
        end
        w_dev = r_raw_mode ? r_s1.sample_offset : w_scaled;
        w_zb  = (w_mag <= r_zb_range);
    end

    // Next bank state for the item in stage 1
    always_comb begin
        n_fill_bank  = r_fill_bank;
        n_fill_word  = r_fill_word;
        n_pend_vld   = r_pend_vld;
        n_pend_bank  = r_pend_bank;
        w_bank_ready = 1'b0;
        w_ovr        = 1'b0;
        if (w_is_smp) begin
            if (r_fill_word == LAST_WORD) begin
                if (r_pend_vld) begin
                    // overrun: keep overwriting the last word of the filling bank
                    w_ovr = 1'b1;
                end else begin
                    n_fill_word  = '0;
                    n_pend_vld   = 1'b1;
                    n_pend_bank  = r_fill_bank;
                    w_bank_ready = 1'b1;
                    n_fill_bank  = (r_fill_bank == LAST_BANK) ? '0 : r_fill_bank + 1'b1;
                end
            end else begin
                n_fill_word = r_fill_word + 1'b1;
            end
        end else if (w_is_rel) begin
            n_pend_vld = 1'b0;
        end
    end

    // Bank state registers advance with stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_bank <= '0;
            r_fill_word <= '0;
            r_pend_vld  <= 1'b0;
            r_pend_bank <= '0;
        end else if (w_adv1) begin
            r_fill_bank <= n_fill_bank;
            r_fill_word <= n_fill_word;
            r_pend_vld  <= n_pend_vld;
            r_pend_bank <= n_pend_bank;
        end
    end

    // Store access: write the sample word, or read the word holding the byte
    assign w_hit   = r_pend_vld && (32'(r_s1.read_index) < 32'(2 * BANK_WORDS));
    assign w_we    = w_adv1 && w_is_smp;
    assign w_re    = w_adv1 && w_is_read;
    assign w_waddr = ADDR_W'(ADDR_W'(r_fill_bank) * ADDR_W'(BANK_WORDS))
                   + ADDR_W'(r_fill_word);
    assign w_raddr = ADDR_W'(ADDR_W'(r_pend_bank) * ADDR_W'(BANK_WORDS))
                   + ADDR_W'(WORD_W'(r_s1.read_index[8:1]));

    osp_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_dev),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Stage 1 result fields, read byte filled in later
    always_comb begin
        w_s1_res            = '0;
        w_s1_res.deviation  = w_is_smp ? w_dev : 16'd0;
        w_s1_res.zero_beat  = w_is_smp && w_zb;
        w_s1_res.bank_ready = w_bank_ready;
        w_s1_res.ready_bank = n_pend_vld && n_pend_bank[0];
        w_s1_res.overrun    = w_ovr;
        w_s1_res.no_pending = !n_pend_vld;
    end

    // Stage 2 register, aligned with the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s2     <= w_s1_res;
            r_s2_hit <= w_is_read && w_hit;
            r_s2_hi  <= r_s1.read_index[0];
        end
    end

    // Pick the byte, little-endian within the word
    assign w_byte = !r_s2_hit ? 8'd0 : (r_s2_hi ? w_rdata[15:8] : w_rdata[7:0]);

    // Merge the read byte into the stage 2 result
    always_comb begin
        w_s2_res           = r_s2;
        w_s2_res.read_data = w_byte;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && w_out_free) begin
            r_out <= w_s2_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    // The pending bank is never the one being filled
    a_pend_not_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_pend_bank != r_fill_bank))
        else $error("pending bank equals filling bank");

    // A store read and a store write never share a cycle
    a_ram_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("store read and write in the same cycle");

    // A bank that just filled or overran leaves a bank pending
    a_ready_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.bank_ready || o_out.overrun)) |-> !o_out.no_pending)
        else $error("bank_ready or overrun without a pending bank");

    // Read data is only nonzero for a read beat with a bank pending
    a_read_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.no_pending) |-> (o_out.read_data == 8'd0))
        else $error("read data returned with no bank pending");

endmodule

`default_nettype wire

[src/osp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module osp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; hold data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
